[design/pmst_pkg.sv]
// shared types and constants for the prim minimum spanning tree core
// no dependencies
`default_nettype none

package pmst_pkg;

    localparam int PMST_MAX_NODES = 32;

    localparam int NODE_W   = 5;
    localparam int WEIGHT_W = 10;
    localparam int KEY_W    = 11;
    localparam int TOTAL_W  = 15;
    localparam int CFG_W    = 6;
    localparam int CNT_CFG_W = 6;
    localparam int START_W  = 5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(1000);
    localparam logic [KEY_W-1:0]    KEY_NONE   = {KEY_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_START_NODE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
    } req_beat_t;

    typedef struct packed {
        logic [NODE_W-1:0]   tree_from;
        logic [NODE_W-1:0]   tree_to;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [TOTAL_W-1:0]  total_weight;
        logic                no_path;
        logic                last;
    } rsp_beat_t;

endpackage

`default_nettype wire

[design/prim_minimum_spanning_tree_core.sv]
// prim minimum spanning tree core over a symmetric adjacency weight memory
// depends on pmst_pkg
// a load beat makes two memory writes, one for each direction; a run scans the weight
// memory row of the last joined node, then emits the next node to join, and an emit
// waits while the output register stays full
// throughput: one beat at a time; results leave through an output register
// reset: a clearing pass writes zero to all MAX_NODES*MAX_NODES weight
// entries while no beat is accepted
`default_nettype none

module prim_minimum_spanning_tree_core
    import pmst_pkg::*;
#(
    parameter int MAX_NODES = PMST_MAX_NODES
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_beat_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_beat_t      rsp
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = 7;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WR2   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [WEIGHT_W-1:0] wmem [DEPTH];
    logic [KEY_W-1:0]    kmem [MAX_NODES];
    logic [NW-1:0]       pmem [MAX_NODES];

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [AW-1:0]        wr2_addr_reg, wr2_addr_next;
    logic [WEIGHT_W-1:0]  wr2_w_reg, wr2_w_next;
    logic [CNT_CFG_W-1:0] node_count_reg, node_count_next;
    logic [START_W-1:0]   start_node_reg, start_node_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [NW-1:0]        u_reg, u_next;
    logic [CW-1:0]        vcnt_reg, vcnt_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic [NW-1:0]        s1_v_reg, s1_v_next;
    logic                 first_reg, first_next;
    logic [CW-1:0]        joined_reg, joined_next;
    logic [MAX_NODES-1:0] in_tree_reg, in_tree_next;
    logic [KEY_W-1:0]     min_key_reg, min_key_next;
    logic [NW-1:0]        min_v_reg, min_v_next;
    logic [NW-1:0]        min_par_reg, min_par_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_beat_t            out_reg, out_next;

    logic [WEIGHT_W-1:0] w_q_reg;
    logic [KEY_W-1:0]    k_q_reg;
    logic [NW-1:0]       p_q_reg;

    logic                wm_we;
    logic [AW-1:0]       wm_waddr;
    logic [WEIGHT_W-1:0] wm_wdata;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                km_we;
    logic [KEY_W-1:0]    new_key;
    logic [NW-1:0]       new_par;
    logic [KEY_W-1:0]    old_key;
    logic                cand;
    logic                take;
    logic                accept;
    logic                load_ok;
    logic [WEIGHT_W-1:0] w_sat;
    logic [XW-1:0]       cnt_x;
    logic [CW-1:0]       n_sel;
    logic [NW-1:0]       s_sel;
    logic                out_free;
    logic                is_last;
    logic [TOTAL_W-1:0]  total_sum;

    // weight memory
    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            wmem[wm_waddr] <= wm_wdata;
        end
        if (rd_en)
        begin
            w_q_reg <= wmem[rd_addr];
        end
    end

    // key and parent memories
    always_ff @(posedge clk)
    begin
        if (km_we)
        begin
            kmem[s1_v_reg] <= new_key;
            pmem[s1_v_reg] <= new_par;
        end
        if (rd_en)
        begin
            k_q_reg <= kmem[vcnt_reg[NW-1:0]];
            p_q_reg <= pmem[vcnt_reg[NW-1:0]];
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    // load checks
    assign load_ok = (req.node_a != req.node_b)
                  && (XW'(req.node_a) < XW'(MAX_NODES))
                  && (XW'(req.node_b) < XW'(MAX_NODES));
    assign w_sat   = (req.weight > WEIGHT_MAX) ? WEIGHT_MAX : req.weight;

    // run setup
    assign cnt_x = XW'(node_count_reg);
    always_comb
    begin
        priority if (cnt_x < XW'(2))
        begin
            n_sel = CW'(2);
        end
        else if (cnt_x > XW'(MAX_NODES))
        begin
            n_sel = CW'(MAX_NODES);
        end
        else
        begin
            n_sel = CW'(cnt_x);
        end
    end
    assign s_sel = (XW'(start_node_reg) < XW'(n_sel)) ? NW'(start_node_reg) : '0;

    // memory ports
    assign rd_en   = (state_reg == ST_SCAN) && (vcnt_reg < n_reg);
    assign rd_addr = AW'(u_reg) * AW'(MAX_NODES) + AW'(vcnt_reg[NW-1:0]);

    always_comb
    begin
        wm_we    = 1'b0;
        wm_waddr = wr2_addr_reg;
        wm_wdata = wr2_w_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wm_we    = 1'b1;
                wm_waddr = clr_addr_reg;
                wm_wdata = '0;
            end
            ST_IDLE:
            begin
                wm_we    = accept && (req.op == OP_LOAD) && load_ok;
                wm_waddr = AW'(NW'(req.node_a)) * AW'(MAX_NODES) + AW'(NW'(req.node_b));
                wm_wdata = w_sat;
            end
            ST_WR2:
            begin
                wm_we = 1'b1;
            end
            default:
            begin
                wm_we = 1'b0;
            end
        endcase
    end

    // compare unit
    assign old_key = first_reg ? KEY_NONE : k_q_reg;
    assign cand    = !in_tree_reg[s1_v_reg] && (w_q_reg != '0)
                  && (KEY_W'(w_q_reg) < old_key);
    assign new_key = cand ? KEY_W'(w_q_reg) : old_key;
    assign new_par = cand ? u_reg : p_q_reg;
    assign take    = !in_tree_reg[s1_v_reg] && (new_key < min_key_reg);
    assign km_we   = (state_reg == ST_SCAN) && s1_vld_reg && (cand || first_reg);

    assign is_last   = ((CW + 1)'(joined_reg) + (CW + 1)'(1)) == (CW + 1)'(n_reg);
    assign total_sum = total_reg + TOTAL_W'(min_key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_w_next      = wr2_w_reg;
        node_count_next = node_count_reg;
        start_node_next = start_node_reg;
        n_next          = n_reg;
        u_next          = u_reg;
        vcnt_next       = vcnt_reg;
        s1_vld_next     = 1'b0;
        s1_v_next       = s1_v_reg;
        first_next      = first_reg;
        joined_next     = joined_reg;
        in_tree_next    = in_tree_reg;
        min_key_next    = min_key_reg;
        min_v_next      = min_v_reg;
        min_par_next    = min_par_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_NODE_COUNT: node_count_next = CNT_CFG_W'(cfg_wdata);
                CFG_START_NODE: start_node_next = START_W'(cfg_wdata);
                default:        node_count_next = node_count_reg;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_RUN)
                    begin
                        n_next       = n_sel;
                        u_next       = s_sel;
                        in_tree_next = MAX_NODES'(1) << s_sel;
                        total_next   = '0;
                        joined_next  = CW'(1);
                        first_next   = 1'b1;
                        vcnt_next    = '0;
                        min_key_next = KEY_NONE;
                        state_next   = ST_SCAN;
                    end
                    else if (load_ok)
                    begin
                        wr2_addr_next = AW'(NW'(req.node_b)) * AW'(MAX_NODES)
                                      + AW'(NW'(req.node_a));
                        wr2_w_next    = w_sat;
                        state_next    = ST_WR2;
                    end
                end
            end
            ST_WR2:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    vcnt_next   = vcnt_reg + CW'(1);
                    s1_vld_next = 1'b1;
                    s1_v_next   = vcnt_reg[NW-1:0];
                end
                if (s1_vld_reg)
                begin
                    if (take)
                    begin
                        min_key_next = new_key;
                        min_v_next   = s1_v_reg;
                        min_par_next = new_par;
                    end
                    if ((CW'(s1_v_reg) + CW'(1)) == n_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (min_key_reg != KEY_NONE)
                    begin
                        out_next.tree_from    = NODE_W'(min_par_reg);
                        out_next.tree_to      = NODE_W'(min_v_reg);
                        out_next.edge_weight  = WEIGHT_W'(min_key_reg);
                        out_next.total_weight = total_sum;
                        out_next.no_path      = 1'b0;
                        out_next.last         = is_last;
                        total_next            = total_sum;
                        in_tree_next[min_v_reg] = 1'b1;
                        joined_next           = joined_reg + CW'(1);
                        u_next                = min_v_reg;
                        first_next            = 1'b0;
                        vcnt_next             = '0;
                        min_key_next          = KEY_NONE;
                        state_next            = is_last ? ST_IDLE : ST_SCAN;
                    end
                    else
                    begin
                        out_next.tree_from    = '0;
                        out_next.tree_to      = '0;
                        out_next.edge_weight  = '0;
                        out_next.total_weight = total_reg;
                        out_next.no_path      = 1'b1;
                        out_next.last         = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            node_count_reg <= CNT_CFG_W'(2);
            start_node_reg <= '0;
            s1_vld_reg     <= 1'b0;
            in_tree_reg    <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            first_reg      <= 1'b1;
            joined_reg     <= '0;
            vcnt_reg       <= '0;
            n_reg          <= CW'(2);
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            node_count_reg <= node_count_next;
            start_node_reg <= start_node_next;
            s1_vld_reg     <= s1_vld_next;
            in_tree_reg    <= in_tree_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            first_reg      <= first_next;
            joined_reg     <= joined_next;
            vcnt_reg       <= vcnt_next;
            n_reg          <= n_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr2_addr_reg <= wr2_addr_next;
        wr2_w_reg    <= wr2_w_next;
        u_reg        <= u_next;
        s1_v_reg     <= s1_v_next;
        min_key_reg  <= min_key_next;
        min_v_reg    <= min_v_next;
        min_par_reg  <= min_par_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire
